[src/cst_pkg.sv]
package cst_pkg;

  // Default depth of the word text store.
  localparam int TEXT_MAX_DEF = 32;

  // Result kinds
  localparam logic [4:0] KIND_INT    = 5'd0;
  localparam logic [4:0] KIND_RETURN = 5'd1;
  localparam logic [4:0] KIND_IF     = 5'd2;
  localparam logic [4:0] KIND_ELSE   = 5'd3;
  localparam logic [4:0] KIND_IDENT  = 5'd4;
  localparam logic [4:0] KIND_NUMBER = 5'd5;
  localparam logic [4:0] KIND_PLUS   = 5'd6;
  localparam logic [4:0] KIND_MINUS  = 5'd7;
  localparam logic [4:0] KIND_STAR   = 5'd8;
  localparam logic [4:0] KIND_DIV    = 5'd9;
  localparam logic [4:0] KIND_LBRACE = 5'd10;
  localparam logic [4:0] KIND_RBRACE = 5'd11;
  localparam logic [4:0] KIND_SEMI   = 5'd12;
  localparam logic [4:0] KIND_ASSIGN = 5'd13;
  localparam logic [4:0] KIND_LPAREN = 5'd14;
  localparam logic [4:0] KIND_RPAREN = 5'd15;
  localparam logic [4:0] KIND_COMMA  = 5'd16;
  localparam logic [4:0] KIND_EOF    = 5'd17;

  // Keyword slots in the match vector
  localparam logic [1:0] KW_INT    = 2'd0;
  localparam logic [1:0] KW_RETURN = 2'd1;
  localparam logic [1:0] KW_IF     = 2'd2;
  localparam logic [1:0] KW_ELSE   = 2'd3;
  localparam int         KW_COUNT  = 4;

  localparam logic [7:0] CHAR_SLASH   = "/";
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text_byte;
    logic       token_end;
    logic       truncated;
    logic       run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    EM_DIV,
    EM_OP,
    EM_WORD,
    EM_KW,
    EM_EOF
  } emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      set_comment;
    logic      end_comment;
    logic      set_slash;
    logic      clr_slash;
    logic      start_ident;
    logic      start_number;
    logic      append;
    logic      word_rewind;
    logic      word_step;
    logic      word_clear;
    logic      reset_all;
    logic      emit;
    emit_sel_t emit_sel;
    logic      flush;
  } cst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic letter;
    logic digit;
    logic op_hit;
    logic slash_char;
    logic newline;
    logic mode_ident;
    logic mode_number;
    logic mode_comment;
    logic slash_pend;
    logic fin;
    logic kw_hit;
    logic word_last;
    logic emit_ok;
    logic pend_valid;
  } cst_sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    logic hit;
    case (c)
      "+", "-", "*", "{", "}", ";", "=", "(", ")", ",": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      "=":     k = KIND_ASSIGN;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      ",":     k = KIND_COMMA;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      KW_INT:    n = 3'd3;
      KW_RETURN: n = 3'd6;
      KW_IF:     n = 3'd2;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [1:0] k);
    logic [4:0] n;
    case (k)
      KW_INT:    n = KIND_INT;
      KW_RETURN: n = KIND_RETURN;
      KW_IF:     n = KIND_IF;
      default:   n = KIND_ELSE;
    endcase
    return n;
  endfunction

  // Character p of keyword k; zero past its end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      KW_INT: begin
        case (p)
          3'd0: ch = "i";
          3'd1: ch = "n";
          3'd2: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KW_RETURN: begin
        case (p)
          3'd0: ch = "r";
          3'd1: ch = "e";
          3'd2: ch = "t";
          3'd3: ch = "u";
          3'd4: ch = "r";
          3'd5: ch = "n";
          default: ch = 8'h00;
        endcase
      end
      KW_IF: begin
        case (p)
          3'd0: ch = "i";
          3'd1: ch = "f";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0: ch = "e";
          3'd1: ch = "l";
          3'd2: ch = "s";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

[src/c_subset_tokenizer_top.sv]
// Streaming tokenizer for a small C subset. Source bytes arrive one per in_ beat
// (final_byte marks the last byte of a text) and tokens leave as out_ beats: a keyword,
// operator or EOF is one beat; an identifier or number is one beat per stored character,
// token_end on its last, truncated on all of them when the word ran past TEXT_MAX
// characters. run_last flags the final beat caused by one input byte. One byte is worked
// at a time, by a controller stepping a datapath that holds the scan state and a
// TEXT_MAX-deep word store; the store is read one character per cycle when a word closes,
// unless out_ready stalls it. A byte that extends a word, sits inside a comment or opens
// one after a held slash goes from the decide step to the finish step; one that starts a
// word, yields an operator or is skipped between tokens also passes a handle step. Closing
// a word adds a rewind step and an emit step per stored character (one for a keyword); a
// held divide released by the next byte adds a divide step. The final byte adds steps
// that close an open word, release a held divide and emit EOF. Stalls on out_ready stretch
// all this; the next byte is taken while the previous one's last result waits in out_r.
module c_subset_tokenizer_top import cst_pkg::*; #(
  parameter int TEXT_MAX = TEXT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cst_cmd_t cmd;
  cst_sts_t sts;

  // Sequence each byte: word close, held divide, operator or word start, final flush.
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold scan state, word store, keyword match and the two-deep result stage.
  cst_datapath #(
    .TEXT_MAX (TEXT_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[src/cst_ctrl.sv]
module cst_ctrl import cst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cst_sts_t sts,
  output cst_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_HANDLE,
    S_FIN,
    S_FSLASH,
    S_EOF,
    S_END,
    S_CPREP,
    S_CWORD
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_fin_r, ret_fin_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ret_fin_nxt = ret_fin_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.mode_comment) begin
          if (sts.newline) cmd.end_comment = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.slash_pend) begin
          if (sts.slash_char) begin
            cmd.clr_slash   = 1'b1;
            cmd.set_comment = 1'b1;
            state_nxt       = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end else if (sts.mode_ident || sts.mode_number) begin
          if (sts.digit || (sts.mode_ident && sts.letter)) begin
            cmd.append = 1'b1;
            state_nxt  = S_FIN;
          end else begin
            ret_fin_nxt = 1'b0;
            state_nxt   = S_CPREP;
          end
        end else begin
          state_nxt = S_HANDLE;
        end
      end
      S_DIV: begin
        if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_DIV;
          cmd.clr_slash = 1'b1;
          state_nxt     = S_HANDLE;
        end
      end
      S_HANDLE: begin
        if (sts.letter) begin
          cmd.start_ident = 1'b1;
          state_nxt       = S_FIN;
        end else if (sts.digit) begin
          cmd.start_number = 1'b1;
          state_nxt        = S_FIN;
        end else if (sts.op_hit) begin
          if (sts.emit_ok) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_OP;
            state_nxt    = S_FIN;
          end
        end else if (sts.slash_char) begin
          cmd.set_slash = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.fin) begin
          state_nxt = S_END;
        end else if (sts.mode_ident || sts.mode_number) begin
          ret_fin_nxt = 1'b1;
          state_nxt   = S_CPREP;
        end else begin
          state_nxt = S_FSLASH;
        end
      end
      S_FSLASH: begin
        if (!sts.slash_pend) begin
          state_nxt = S_EOF;
        end else if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_DIV;
          cmd.clr_slash = 1'b1;
          state_nxt     = S_EOF;
        end
      end
      S_EOF: begin
        if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_EOF;
          cmd.reset_all = 1'b1;
          state_nxt     = S_END;
        end
      end
      S_END: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.emit_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CPREP: begin
        cmd.word_rewind = 1'b1;
        state_nxt       = S_CWORD;
      end
      S_CWORD: begin
        if (sts.emit_ok) begin
          cmd.emit = 1'b1;
          if (sts.kw_hit) begin
            cmd.emit_sel   = EM_KW;
            cmd.word_clear = 1'b1;
            state_nxt      = ret_fin_r ? S_FSLASH : S_HANDLE;
          end else begin
            cmd.emit_sel = EM_WORD;
            if (sts.word_last) begin
              cmd.word_clear = 1'b1;
              state_nxt      = ret_fin_r ? S_FSLASH : S_HANDLE;
            end else begin
              cmd.word_step = 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_fin_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_fin_r <= ret_fin_nxt;
    end
  end

endmodule

[src/cst_datapath.sv]
module cst_datapath import cst_pkg::*; #(
  parameter int TEXT_MAX = TEXT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cst_cmd_t  cmd,
  output cst_sts_t  sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int LW = $clog2(TEXT_MAX + 1);
  localparam int AW = $clog2(TEXT_MAX);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic                slash_r, slash_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic                ovf_r, ovf_nxt;
  logic [KW_COUNT-1:0] kwm_r, kwm_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [7:0]          c_r, c_nxt;
  logic                fin_r, fin_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [7:0]    word_mem [TEXT_MAX];
  logic [7:0]    rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic       kw_hit;
  logic [4:0] kw_code;
  logic       word_last;
  logic       out_free;
  out_item_t  new_item;

  assign word_last = ((LW'(idx_r) + LW'(1)) == len_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    kw_hit  = 1'b0;
    kw_code = KIND_INT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kwm_r[k] && (len_r == LW'(kw_len(2'(k))))) begin
        kw_hit  = 1'b1;
        kw_code = kw_kind(2'(k));
      end
    end
    kw_hit = kw_hit && (mode_r == MODE_IDENT) && !ovf_r;
  end

  always_comb begin
    sts.letter       = is_letter(c_r);
    sts.digit        = is_digit(c_r);
    sts.op_hit       = is_op(c_r);
    sts.slash_char   = (c_r == CHAR_SLASH);
    sts.newline      = (c_r == CHAR_NEWLINE);
    sts.mode_ident   = (mode_r == MODE_IDENT);
    sts.mode_number  = (mode_r == MODE_NUMBER);
    sts.mode_comment = (mode_r == MODE_COMMENT);
    sts.slash_pend   = slash_r;
    sts.fin          = fin_r;
    sts.kw_hit       = kw_hit;
    sts.word_last    = word_last;
    sts.emit_ok      = !pend_valid_r || out_free;
    sts.pend_valid   = pend_valid_r;
  end

  // Scan state and word store
  always_comb begin
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    kwm_nxt   = kwm_r;
    idx_nxt   = idx_r;
    c_nxt     = c_r;
    fin_nxt   = fin_r;
    wr_en     = 1'b0;
    wr_addr   = len_r[AW-1:0];
    if (cmd.load) begin
      c_nxt   = in_item.char_code;
      fin_nxt = in_item.final_byte;
    end
    if (cmd.set_comment) mode_nxt = MODE_COMMENT;
    if (cmd.end_comment) mode_nxt = MODE_IDLE;
    if (cmd.set_slash) slash_nxt = 1'b1;
    if (cmd.clr_slash) slash_nxt = 1'b0;
    if (cmd.start_ident || cmd.start_number) begin
      mode_nxt = cmd.start_ident ? MODE_IDENT : MODE_NUMBER;
      wr_en    = 1'b1;
      wr_addr  = '0;
      len_nxt  = LW'(1);
      ovf_nxt  = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
        kwm_nxt[k] = (c_r == kw_char(2'(k), 3'd0));
      end
    end else if (cmd.append) begin
      if (len_r < LW'(TEXT_MAX)) begin
        wr_en   = 1'b1;
        len_nxt = len_r + LW'(1);
        for (int k = 0; k < KW_COUNT; k++) begin
          kwm_nxt[k] = kwm_r[k] && (len_r < LW'(kw_len(2'(k)))) &&
                       (c_r == kw_char(2'(k), len_r[2:0]));
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.word_rewind) idx_nxt = '0;
    if (cmd.word_step) idx_nxt = idx_r + AW'(1);
    if (cmd.word_clear) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
    end
    if (cmd.reset_all) begin
      mode_nxt  = MODE_IDLE;
      slash_nxt = 1'b0;
      len_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // Result composition
  always_comb begin
    new_item = '0;
    new_item.token_end = 1'b1;
    unique case (cmd.emit_sel)
      EM_DIV:  new_item.kind = KIND_DIV;
      EM_OP:   new_item.kind = op_kind(c_r);
      EM_KW:   new_item.kind = kw_code;
      EM_EOF:  new_item.kind = KIND_EOF;
      EM_WORD: begin
        new_item.kind      = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
        new_item.text_byte = rd_data_r;
        new_item.token_end = word_last;
        new_item.truncated = ovf_r;
      end
      default: new_item = '0;
    endcase
  end

  // Pending stage holds the newest result until the next one shows whether it ends the run.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (cmd.emit) begin
      if (pend_valid_r) begin
        out_valid_nxt    = 1'b1;
        out_nxt          = pend_r;
        out_nxt.run_last = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = new_item;
    end else if (cmd.flush) begin
      out_valid_nxt    = 1'b1;
      out_nxt          = pend_r;
      out_nxt.run_last = 1'b1;
      pend_valid_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      slash_r      <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      slash_r      <= slash_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kwm_r  <= kwm_nxt;
    idx_r  <= idx_nxt;
    c_r    <= c_nxt;
    fin_r  <= fin_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) word_mem[wr_addr] <= c_r;
    rd_data_r <= word_mem[idx_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!pend_valid_r || !out_valid_r || out_ready))
    else $error("result emitted with no room in the output stage");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(TEXT_MAX))
    else $error("word length beyond store depth");

  a_len_mode: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER)) == (len_r != '0))
    else $error("word length disagrees with scan mode");

  a_slash_idle: assert property (@(posedge clk) disable iff (!rst_n)
    slash_r |-> (mode_r == MODE_IDLE))
    else $error("held slash while a word or comment is open");

endmodule
